### design/arpr_pkg.sv
`default_nettype none

package arpr_pkg;

  // Frame layout and protocol values.
  localparam int unsigned REPLY_BYTES = 42;
  localparam logic [15:0] ETYPE_ARP      = 16'h0806;
  localparam logic [15:0] ETYPE_RARP     = 16'h8035;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] OPCODE_REPLY   = 16'h0002;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY   = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_PASS    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PORT_COUNT = 3'd0;
  localparam logic [2:0] REG_PORT0_MAC  = 3'd1;
  localparam logic [2:0] REG_PORT1_MAC  = 3'd2;
  localparam logic [2:0] REG_PORT0_IP   = 3'd3;
  localparam logic [2:0] REG_PORT1_IP   = 3'd4;

  localparam logic [1:0] PORT_COUNT_RESET = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    logic       in_port;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] out_kind;
    logic       out_port;
  } out_t;

  typedef struct packed {
    logic [1:0]  port_count;
    logic [47:0] port0_mac;
    logic [47:0] port1_mac;
    logic [31:0] port0_ip;
    logic [31:0] port1_ip;
  } cfg_t;

  // One classified frame waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic        port;
    logic [47:0] requester_mac;
    logic [31:0] sender_ip;
  } job_t;

endpackage

`default_nettype wire

### design/arp_responder_with_port_bridge_top.sv
`default_nettype none

// ARP responder with a two-port bridge verdict. Frame bytes enter through a queue-style
// port (push/full) one transaction per byte, tagged with the ingress port on the first
// byte and with in_last on the final byte. Nothing comes out until the last byte of a
// frame. An ARP frame of at least 42 bytes whose target IP equals the ingress port's IP
// produces a 42-byte ARP reply on that port, one result transaction per byte, kind 0,
// out_last on the final byte; whatever the opcode, the frame is answered and the request
// itself is dropped. Any other ARP or RARP frame produces one result of kind 1 naming
// the other port, or port 0 if port_count is below 2; every other frame produces one
// result of kind 2. Bytes are accepted at one per clock while the job queue has room:
// the front parser classifies each frame at its last byte and drops a compact job into
// a small job queue (JOB_DEPTH entries), and the back end drains that queue at one
// result per clock, while the consumer pops, into an output register. A frame's first
// result passes through the job queue and the output register before it shows on the
// result ports. The only stall on the input side is a full job queue, which happens
// when short frames arrive during a 42-byte reply or while the consumer holds off pop.
// Configuration goes through an APB-style port with 64-bit data; register i sits at
// byte address 8*i (port_count, port0_mac, port1_mac, port0_ip, port1_ip) and should
// only be written while no frame is in flight.
module arp_responder_with_port_bridge_top #(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // Frame byte side.
  input  wire logic            push,
  output logic                 full,
  input  wire arpr_pkg::in_t   item,
  // Result side.
  input  wire logic            pop,
  output logic                 empty,
  output arpr_pkg::out_t       result,
  // Configuration port.
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [5:0]      paddr,
  input  wire logic [63:0]     pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  arpr_pkg::cfg_t cfg;
  arpr_pkg::job_t front_job;
  arpr_pkg::job_t head_job;
  logic           job_push;
  logic           job_pop;
  logic           job_full;
  logic           job_empty;
  logic           accept;
  logic           cfg_write;
  logic [2:0]     reg_index;

  // A byte is taken whenever the job queue has room, so a last byte always has a slot.
  assign full   = job_full;
  assign accept = push && !job_full;

  // The register file. Writes land at the end of the access phase; reads are decoded
  // combinationally since pready is tied high.
  assign pready    = 1'b1;
  assign reg_index = paddr[5:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_count <= arpr_pkg::PORT_COUNT_RESET;
      cfg.port0_mac  <= 48'd0;
      cfg.port1_mac  <= 48'd0;
      cfg.port0_ip   <= 32'd0;
      cfg.port1_ip   <= 32'd0;
    end else if (cfg_write) begin
      case (reg_index)
        arpr_pkg::REG_PORT_COUNT: cfg.port_count <= pwdata[1:0];
        arpr_pkg::REG_PORT0_MAC:  cfg.port0_mac  <= pwdata[47:0];
        arpr_pkg::REG_PORT1_MAC:  cfg.port1_mac  <= pwdata[47:0];
        arpr_pkg::REG_PORT0_IP:   cfg.port0_ip   <= pwdata[31:0];
        arpr_pkg::REG_PORT1_IP:   cfg.port1_ip   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      arpr_pkg::REG_PORT_COUNT: prdata = {62'd0, cfg.port_count};
      arpr_pkg::REG_PORT0_MAC:  prdata = {16'd0, cfg.port0_mac};
      arpr_pkg::REG_PORT1_MAC:  prdata = {16'd0, cfg.port1_mac};
      arpr_pkg::REG_PORT0_IP:   prdata = {32'd0, cfg.port0_ip};
      arpr_pkg::REG_PORT1_IP:   prdata = {32'd0, cfg.port1_ip};
      default:                  prdata = 64'd0;
    endcase
  end

  arpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (front_job)
  );

  arpr_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .pop      (job_pop),
    .head     (head_job),
    .full     (job_full),
    .empty    (job_empty)
  );

  arpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (head_job),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

`default_nettype wire

### design/arpr_front.sv
`default_nettype none

module arpr_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire arpr_pkg::in_t  item,
  input  wire arpr_pkg::cfg_t cfg,
  output logic                job_push,
  output arpr_pkg::job_t      job
);

  logic [5:0]  byte_position;
  logic        frame_port;
  logic [15:0] frame_ethertype;
  logic [47:0] requester_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;

  logic        frame_port_next;
  logic [15:0] frame_ethertype_next;
  logic [47:0] requester_mac_next;
  logic [31:0] sender_ip_next;
  logic [31:0] target_ip_next;
  logic [5:0]  byte_position_next;
  logic        first;
  logic        is_arp;
  logic        is_rarp;
  logic        long_enough;
  logic [31:0] my_ip;

  assign first = (byte_position == 6'd0);

  always_comb begin
    frame_port_next      = first ? item.in_port : frame_port;
    frame_ethertype_next = first ? 16'd0 : frame_ethertype;
    requester_mac_next   = first ? 48'd0 : requester_mac;
    sender_ip_next       = first ? 32'd0 : sender_ip;
    target_ip_next       = first ? 32'd0 : target_ip;
    if (byte_position inside {[6'd6:6'd11]}) begin
      requester_mac_next = {requester_mac[39:0], item.in_byte};
    end else if (byte_position inside {[6'd12:6'd13]}) begin
      frame_ethertype_next = {frame_ethertype[7:0], item.in_byte};
    end else if (byte_position inside {[6'd28:6'd31]}) begin
      sender_ip_next = {sender_ip[23:0], item.in_byte};
    end else if (byte_position inside {[6'd38:6'd41]}) begin
      target_ip_next = {target_ip[23:0], item.in_byte};
    end
    if (item.in_last) begin
      byte_position_next = 6'd0;
    end else if (byte_position != 6'd63) begin
      byte_position_next = byte_position + 6'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  // The frame counts as long enough once the byte at the last reply position arrives.
  assign long_enough = (byte_position >= 6'(arpr_pkg::REPLY_BYTES - 1));
  assign my_ip       = frame_port_next ? cfg.port1_ip : cfg.port0_ip;
  assign is_arp      = (frame_ethertype_next == arpr_pkg::ETYPE_ARP);
  assign is_rarp     = (frame_ethertype_next == arpr_pkg::ETYPE_RARP);

  always_comb begin
    job.port          = 1'b0;
    job.requester_mac = requester_mac_next;
    job.sender_ip     = sender_ip_next;
    if (is_arp && long_enough && (target_ip_next == my_ip)) begin
      job.kind = arpr_pkg::KIND_REPLY;
      job.port = frame_port_next;
    end else if (is_arp || is_rarp) begin
      job.kind = arpr_pkg::KIND_FORWARD;
      job.port = !frame_port_next && (cfg.port_count >= 2'd2);
    end else begin
      job.kind = arpr_pkg::KIND_PASS;
    end
  end

  assign job_push = accept && item.in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 6'd0;
      frame_port      <= 1'b0;
      frame_ethertype <= 16'd0;
      requester_mac   <= 48'd0;
      sender_ip       <= 32'd0;
      target_ip       <= 32'd0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      frame_port      <= frame_port_next;
      frame_ethertype <= frame_ethertype_next;
      requester_mac   <= requester_mac_next;
      sender_ip       <= sender_ip_next;
      target_ip       <= target_ip_next;
    end
  end

endmodule

`default_nettype wire

### design/arpr_job_fifo.sv
`default_nettype none

module arpr_job_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire arpr_pkg::job_t push_job,
  input  wire logic           pop,
  output arpr_pkg::job_t      head,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  arpr_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/arpr_back.sv
`default_nettype none

module arpr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire arpr_pkg::cfg_t cfg,
  input  wire arpr_pkg::job_t job,
  input  wire logic           job_empty,
  output logic                job_pop,
  input  wire logic           pop,
  output logic                empty,
  output arpr_pkg::out_t      result
);

  logic [5:0]     idx;
  logic           out_valid;
  arpr_pkg::out_t out_reg;
  logic           advance;
  logic           produce;
  logic           reply;
  logic           last_byte;
  logic [47:0]    my_mac;
  logic [31:0]    my_ip;
  logic [7:0]     reply_byte;
  arpr_pkg::out_t next_out;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  assign my_mac = job.port ? cfg.port1_mac : cfg.port0_mac;
  assign my_ip  = job.port ? cfg.port1_ip : cfg.port0_ip;

  always_comb begin
    case (idx) inside
      [6'd0:6'd5]:   reply_byte = mac_byte(job.requester_mac, idx[2:0]);
      [6'd6:6'd11]:  reply_byte = mac_byte(my_mac, 3'(idx - 6'd6));
      6'd12:         reply_byte = arpr_pkg::ETYPE_ARP[15:8];
      6'd13:         reply_byte = arpr_pkg::ETYPE_ARP[7:0];
      6'd14:         reply_byte = arpr_pkg::HTYPE_ETHERNET[15:8];
      6'd15:         reply_byte = arpr_pkg::HTYPE_ETHERNET[7:0];
      6'd16:         reply_byte = arpr_pkg::ETYPE_IPV4[15:8];
      6'd17:         reply_byte = arpr_pkg::ETYPE_IPV4[7:0];
      6'd18:         reply_byte = arpr_pkg::HW_ADDR_LEN;
      6'd19:         reply_byte = arpr_pkg::PROTO_ADDR_LEN;
      6'd20:         reply_byte = arpr_pkg::OPCODE_REPLY[15:8];
      6'd21:         reply_byte = arpr_pkg::OPCODE_REPLY[7:0];
      [6'd22:6'd27]: reply_byte = mac_byte(my_mac, 3'(idx - 6'd22));
      [6'd28:6'd31]: reply_byte = ip_byte(my_ip, idx[1:0]);
      [6'd32:6'd37]: reply_byte = mac_byte(job.requester_mac, 3'(idx - 6'd32));
      [6'd38:6'd41]: reply_byte = ip_byte(job.sender_ip, 2'(idx - 6'd38));
      default:       reply_byte = 8'd0;
    endcase
  end

  assign reply     = (job.kind == arpr_pkg::KIND_REPLY);
  assign last_byte = (idx == 6'(arpr_pkg::REPLY_BYTES - 1));
  assign advance   = !out_valid || pop;
  assign produce   = advance && !job_empty;
  assign job_pop   = produce && (!reply || last_byte);

  always_comb begin
    next_out.out_kind = job.kind;
    next_out.out_port = job.port;
    if (reply) begin
      next_out.out_byte = reply_byte;
      next_out.out_last = last_byte;
    end else begin
      next_out.out_byte = 8'd0;
      next_out.out_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_reg <= next_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (produce) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (job_pop) begin
        idx <= 6'd0;
      end else if (produce) begin
        idx <= idx + 6'd1;
      end
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

`default_nettype wire

### dv/arpr_checker.sv
`default_nettype none

// Watches the byte, result and register channels of the ARP responder, keeps its
// own copy of the parser state and the port registers, predicts the results of
// every frame, and compares them in order with what the block delivers.
module arpr_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic           full,
  input  wire arpr_pkg::in_t  item,
  input  wire logic           pop,
  input  wire logic           empty,
  input  wire arpr_pkg::out_t result,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [5:0]     paddr,
  input  wire logic [63:0]    pwdata,
  input  wire logic           pready,
  output int                  errors,
  output int                  awaited,
  output int                  replies_seen,
  output int                  forwards_seen,
  output int                  passes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  arpr_pkg::cfg_t port_regs;
  logic [5:0]     rx_pos;
  logic           rx_port;
  logic [15:0]    rx_ethertype;
  logic [47:0]    rx_src_mac;
  logic [31:0]    rx_sender_ip;
  logic [31:0]    rx_target_ip;
  arpr_pkg::out_t egress_due[$];

  // Takes one frame byte and, on the last byte, queues the results the frame causes.
  task automatic absorb_frame_byte(input arpr_pkg::in_t it);
    logic [5:0]     count;
    logic [31:0]    own_ip;
    logic [47:0]    own_mac;
    logic [1:0]     active;
    logic [7:0]     reply [0:arpr_pkg::REPLY_BYTES-1];
    arpr_pkg::out_t r;
    if (rx_pos == 6'd0) begin
      rx_port      = it.in_port;
      rx_ethertype = '0;
      rx_src_mac   = '0;
      rx_sender_ip = '0;
      rx_target_ip = '0;
    end
    if (rx_pos >= 6 && rx_pos < 12) rx_src_mac = {rx_src_mac[39:0], it.in_byte};
    else if (rx_pos >= 12 && rx_pos < 14) rx_ethertype = {rx_ethertype[7:0], it.in_byte};
    else if (rx_pos >= 28 && rx_pos < 32) rx_sender_ip = {rx_sender_ip[23:0], it.in_byte};
    else if (rx_pos >= 38 && rx_pos < 42) rx_target_ip = {rx_target_ip[23:0], it.in_byte};

    count = (rx_pos < 6'd63) ? rx_pos + 6'd1 : 6'd63;
    if (!it.in_last) begin
      rx_pos = count;
      return;
    end
    rx_pos = 6'd0;

    own_ip  = rx_port ? port_regs.port1_ip : port_regs.port0_ip;
    own_mac = rx_port ? port_regs.port1_mac : port_regs.port0_mac;
    active  = (port_regs.port_count > 2'd2) ? 2'd2 : port_regs.port_count;

    if (rx_ethertype == arpr_pkg::ETYPE_ARP && count >= arpr_pkg::REPLY_BYTES &&
        rx_target_ip == own_ip) begin
      for (int i = 0; i < 6; i++) begin
        reply[i]      = rx_src_mac[8*(5-i) +: 8];
        reply[6 + i]  = own_mac[8*(5-i) +: 8];
        reply[22 + i] = own_mac[8*(5-i) +: 8];
        reply[32 + i] = rx_src_mac[8*(5-i) +: 8];
      end
      reply[12] = arpr_pkg::ETYPE_ARP[15:8];
      reply[13] = arpr_pkg::ETYPE_ARP[7:0];
      reply[14] = arpr_pkg::HTYPE_ETHERNET[15:8];
      reply[15] = arpr_pkg::HTYPE_ETHERNET[7:0];
      reply[16] = arpr_pkg::ETYPE_IPV4[15:8];
      reply[17] = arpr_pkg::ETYPE_IPV4[7:0];
      reply[18] = arpr_pkg::HW_ADDR_LEN;
      reply[19] = arpr_pkg::PROTO_ADDR_LEN;
      reply[20] = arpr_pkg::OPCODE_REPLY[15:8];
      reply[21] = arpr_pkg::OPCODE_REPLY[7:0];
      for (int i = 0; i < 4; i++) begin
        reply[28 + i] = own_ip[8*(3-i) +: 8];
        reply[38 + i] = rx_sender_ip[8*(3-i) +: 8];
      end
      for (int i = 0; i < arpr_pkg::REPLY_BYTES; i++) begin
        r.out_byte = reply[i];
        r.out_last = (i == arpr_pkg::REPLY_BYTES - 1);
        r.out_kind = arpr_pkg::KIND_REPLY;
        r.out_port = rx_port;
        egress_due.push_back(r);
      end
    end else if (rx_ethertype == arpr_pkg::ETYPE_ARP ||
                 rx_ethertype == arpr_pkg::ETYPE_RARP) begin
      r.out_byte = 8'd0;
      r.out_last = 1'b1;
      r.out_kind = arpr_pkg::KIND_FORWARD;
      r.out_port = (rx_port == 1'b0 && active > 2'd1);
      egress_due.push_back(r);
    end else begin
      r.out_byte = 8'd0;
      r.out_last = 1'b1;
      r.out_kind = arpr_pkg::KIND_PASS;
      r.out_port = 1'b0;
      egress_due.push_back(r);
    end
  endtask

  task automatic match_result(input arpr_pkg::out_t got);
    arpr_pkg::out_t want;
    if (egress_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: byte %02h last %0b kind %0d port %0b",
               $time, got.out_byte, got.out_last, got.out_kind, got.out_port);
      return;
    end
    want = egress_due.pop_front();
    if (got.out_byte !== want.out_byte) begin
      errors++;
      $display("%0t: out_byte expected %02h, got %02h", $time, want.out_byte, got.out_byte);
    end
    if (got.out_last !== want.out_last) begin
      errors++;
      $display("%0t: out_last expected %0b, got %0b", $time, want.out_last, got.out_last);
    end
    if (got.out_kind !== want.out_kind) begin
      errors++;
      $display("%0t: out_kind expected %0d, got %0d", $time, want.out_kind, got.out_kind);
    end
    if (got.out_port !== want.out_port) begin
      errors++;
      $display("%0t: out_port expected %0b, got %0b", $time, want.out_port, got.out_port);
    end
    case (got.out_kind)
      arpr_pkg::KIND_REPLY:   replies_seen++;
      arpr_pkg::KIND_FORWARD: forwards_seen++;
      default:                passes_seen++;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_regs     = '0;
      port_regs.port_count = arpr_pkg::PORT_COUNT_RESET;
      rx_pos        = '0;
      rx_port       = 1'b0;
      rx_ethertype  = '0;
      rx_src_mac    = '0;
      rx_sender_ip  = '0;
      rx_target_ip  = '0;
      egress_due.delete();
      errors        = 0;
      replies_seen  = 0;
      forwards_seen = 0;
      passes_seen   = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          arpr_pkg::REG_PORT_COUNT: port_regs.port_count = pwdata[1:0];
          arpr_pkg::REG_PORT0_MAC:  port_regs.port0_mac  = pwdata[47:0];
          arpr_pkg::REG_PORT1_MAC:  port_regs.port1_mac  = pwdata[47:0];
          arpr_pkg::REG_PORT0_IP:   port_regs.port0_ip   = pwdata[31:0];
          arpr_pkg::REG_PORT1_IP:   port_regs.port1_ip   = pwdata[31:0];
          default: ;
        endcase
      end
      // The result is matched first so that a byte taken at the same edge cannot
      // supply an expectation for it.
      if (pop && !empty) match_result(result);
      if (push && !full) absorb_frame_byte(item);
    end
    awaited = egress_due.size();
  end

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

// Top of the ARP responder testbench. This module only makes stimulus and gives
// the verdict; all prediction and comparison lives in the checker beside the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst;
  logic           push;
  logic           full;
  arpr_pkg::in_t  item;
  logic           pop;
  logic           empty;
  arpr_pkg::out_t result;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [5:0]     paddr;
  logic [63:0]    pwdata;
  logic [63:0]    prdata;
  logic           pready;

  int errors;
  int awaited;
  int replies_seen;
  int forwards_seen;
  int passes_seen;

  // Stimulus bookkeeping. The IP copy is only used to aim ARP targets at the
  // address a port answers to; it plays no part in checking.
  logic [31:0] port_ip [0:1];
  logic [7:0]  frame_bytes [0:79];
  int          frame_len;
  int          burst_left = 0;
  logic        gaps_on = 1'b1;
  logic        hold_off_req;
  int          bytes_sent = 0;
  int          frames_sent = 0;

  arp_responder_with_port_bridge_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  arpr_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .pop           (pop),
    .empty         (empty),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors        (errors),
    .awaited       (awaited),
    .replies_seen  (replies_seen),
    .forwards_seen (forwards_seen),
    .passes_seen   (passes_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One APB write: a setup phase, then an access phase that completes on the edge
  // where pready is seen high.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] count, input logic [47:0] mac0,
                           input logic [47:0] mac1, input logic [31:0] ip0,
                           input logic [31:0] ip1);
    write_reg(arpr_pkg::REG_PORT_COUNT, {62'd0, count});
    write_reg(arpr_pkg::REG_PORT0_MAC, {16'd0, mac0});
    write_reg(arpr_pkg::REG_PORT1_MAC, {16'd0, mac1});
    write_reg(arpr_pkg::REG_PORT0_IP, {32'd0, ip0});
    write_reg(arpr_pkg::REG_PORT1_IP, {32'd0, ip1});
    port_ip[0] = ip0;
    port_ip[1] = ip1;
  endtask

  // Registers may only change once every predicted result has drained. Every
  // frame here ends with in_last, so after the drain only the back-end pipeline
  // can still be busy; a short pause covers it. The first edge lets the checker
  // take in the byte accepted just before the call.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Offers one byte transaction and returns on the edge that accepts it. The
  // sender runs in bursts; while gaps are on, push drops for a random gap between bursts.
  task automatic offer(input arpr_pkg::in_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // Lays out an Ethernet frame with an ARP-shaped body; whatever the frame length
  // cuts off is simply never sent. Bytes not set here stay random.
  task automatic build_frame(input logic [15:0] ethertype, input logic [31:0] target,
                             input int len);
    for (int i = 0; i < 80; i++) frame_bytes[i] = 8'($urandom);
    frame_len = len;
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 6; i++) frame_bytes[i] = 8'hFF;
    end
    frame_bytes[12] = ethertype[15:8];
    frame_bytes[13] = ethertype[7:0];
    frame_bytes[14] = arpr_pkg::HTYPE_ETHERNET[15:8];
    frame_bytes[15] = arpr_pkg::HTYPE_ETHERNET[7:0];
    frame_bytes[16] = arpr_pkg::ETYPE_IPV4[15:8];
    frame_bytes[17] = arpr_pkg::ETYPE_IPV4[7:0];
    frame_bytes[18] = arpr_pkg::HW_ADDR_LEN;
    frame_bytes[19] = arpr_pkg::PROTO_ADDR_LEN;
    frame_bytes[20] = 8'd0;
    frame_bytes[21] = 8'($urandom_range(1, 4));
    for (int i = 0; i < 4; i++) frame_bytes[38 + i] = target[8*(3-i) +: 8];
  endtask

  // The ingress port only counts on the first byte, so the later bytes carry
  // random port values to show that they are ignored.
  task automatic send_frame(input logic port);
    arpr_pkg::in_t it;
    for (int i = 0; i < frame_len; i++) begin
      it.in_byte = frame_bytes[i];
      it.in_last = (i == frame_len - 1);
      it.in_port = (i == 0) ? port : 1'($urandom);
      offer(it);
    end
    frames_sent++;
  endtask

  // The receiver pops in modes picked at random from time to time: free running,
  // coin flip, or mostly stalled. Once asked, it also holds off for a long
  // stretch so the job queue fills and the block pushes back on the sender.
  initial begin : result_drain
    int   mode;
    int   mode_left;
    logic held_once;
    pop <= 1'b0;
    mode = 0;
    mode_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held_once) begin
        held_once = 1'b1;
        pop <= 1'b0;
        for (int c = 0; c < 700; c++) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    rst          <= 1'b1;
    push         <= 1'b0;
    item         <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    hold_off_req <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two active ports with distinct addresses for the directed frames.
    configure(2'd2, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              32'hC0A8_0001, 32'h0A00_00FE);

    // A reply to a frame long enough to run the byte counter into saturation.
    build_frame(arpr_pkg::ETYPE_ARP, port_ip[0], 65); send_frame(1'b0);
    // A matching ARP frame one byte short is only forwarded, and RARP with a
    // matching target is forwarded from port zero to port one.
    build_frame(arpr_pkg::ETYPE_ARP, port_ip[1], 41); send_frame(1'b1);
    build_frame(arpr_pkg::ETYPE_RARP, port_ip[0], 14); send_frame(1'b0);
    // Pass-on: single-byte frames at both byte extremes, and a frame cut inside
    // its ethertype.
    build_frame(arpr_pkg::ETYPE_IPV4, 32'd0, 1); frame_bytes[0] = 8'hFF; send_frame(1'b1);
    build_frame(arpr_pkg::ETYPE_IPV4, 32'd0, 1); frame_bytes[0] = 8'h00; send_frame(1'b0);
    build_frame(arpr_pkg::ETYPE_ARP, port_ip[0], 13); send_frame(1'b0);

    // One port active: forwards from port zero must stay on port zero.
    settle();
    configure(2'd1, 48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF, 32'h0);
    build_frame(arpr_pkg::ETYPE_RARP, port_ip[0], 14); send_frame(1'b0);

    // A port count of zero behaves as one port. The short ARP frame never reaches
    // its target field, whose cleared value equals port zero's address, and still
    // must not be answered.
    settle();
    configure(2'd0, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              32'h0, 32'hFFFF_FFFF);
    build_frame(arpr_pkg::ETYPE_ARP, 32'h0, 14); send_frame(1'b0);

    // A port count of three behaves as two. This phase also carries the long
    // receiver hold-off: back-to-back short frames keep arriving until the job
    // queue fills and full stalls the sender.
    settle();
    configure(2'd3, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              $urandom, $urandom);
    gaps_on = 1'b0;
    burst_left = 1000;
    hold_off_req <= 1'b1;
    for (int n = 0; n < 6; n++) begin
      build_frame(arpr_pkg::ETYPE_IPV4, 32'd0, 1);
      send_frame(1'(n % 2));
    end
    gaps_on = 1'b1;
    burst_left = 0;
    build_frame(arpr_pkg::ETYPE_RARP, port_ip[0], 14); send_frame(1'b0);

    settle();
    repeat (60) @(posedge clk);
    $display("Ran %0d frames (%0d byte transactions) over four port-count settings,",
             frames_sent, bytes_sent);
    $display("with one long receiver stall; saw %0d reply bytes, %0d forwards, %0d pass-ons.",
             replies_seen, forwards_seen, passes_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the slowest legal run, including the long receiver hold-off.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout waiting for the block to finish.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

### arp_responder_with_port_bridge_top.f
design/arpr_pkg.sv
design/arpr_front.sv
design/arpr_job_fifo.sv
design/arpr_back.sv
design/arp_responder_with_port_bridge_top.sv
dv/arpr_checker.sv
dv/tb.sv
